// ----- design/r3d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// r3d_pkg: shared types, constants and functions for the Euler rotator
// Number formats, the quarter-wave sine ROM built at elaboration, the angle
// to ROM index mapping, and the round/shift/saturate used by every axis.
// ---------------------------------------------------------------------------
package r3d_pkg;

  localparam int COORD_BITS      = 32;
  localparam int ANGLE_BITS      = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TRIG_BITS       = 16;   // Q1.15
  localparam int FRAC_SHIFT      = 15;

  localparam int TAB_SIZE  = 1 << SINE_TABLE_BITS;
  localparam int QUARTER   = TAB_SIZE / 4;
  localparam int PROD_BITS = COORD_BITS + TRIG_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;
  localparam int SHR_BITS  = SUM_BITS - FRAC_SHIFT;

  // stream packing, whole bytes
  localparam int IN_RAW_BITS   = 3 * COORD_BITS + 3 * ANGLE_BITS;
  localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = 3 * COORD_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // QUARTER is a power of two: step and remainder by shift and mask
  localparam int          QUARTER_LOG2 = SINE_TABLE_BITS - 2;
  localparam logic [63:0] TH_STEP      = HALF_PI_Q62 >> QUARTER_LOG2;
  localparam logic [63:0] TH_REM       = HALF_PI_Q62 & 64'(QUARTER - 1);

  typedef logic signed [COORD_BITS-1:0]    coord_t;
  typedef logic signed [TRIG_BITS-1:0]     trig_t;
  typedef logic signed [PROD_BITS-1:0]     prod_t;
  typedef logic signed [SUM_BITS-1:0]      sum_t;
  typedef logic signed [SHR_BITS-1:0]      shr_t;
  typedef logic [ANGLE_BITS-1:0]           angle_t;
  typedef logic [SINE_TABLE_BITS-1:0]      tidx_t;
  typedef logic [SINE_TABLE_BITS-2:0]      qidx_t;   // 0 .. QUARTER
  typedef logic [QUARTER:0][TRIG_BITS-1:0] qtab_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam trig_t  TRIG_MIN  = {1'b1, {(TRIG_BITS-1){1'b0}}};
  localparam qidx_t  QUARTER_Q = qidx_t'(QUARTER);
  localparam tidx_t  QUARTER_T = tidx_t'(QUARTER);
  localparam sum_t   ROUND_BIAS = sum_t'(1) <<< (FRAC_SHIFT - 1);

  // raw input point as it leaves the slave port
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    angle_t tx;
    angle_t ty;
    angle_t tz;
  } pin_t;

  // everything that rides along the pipe
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    trig_t  sx;
    trig_t  cx;
    trig_t  sy;
    trig_t  cy;
    trig_t  sz;
    trig_t  cz;
    logic   clip;
  } item_t;

  typedef struct packed {
    coord_t v;
    logic   clip;
  } sat_t;

  // ---- elaboration-time ROM build (Q62 Taylor series) ----
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned shift/subtract quotient, truncated; used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [TRIG_BITS-1:0] quarter_sine(input int k);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    th = TH_STEP * 64'(k) + ((TH_REM * 64'(k)) >> QUARTER_LOG2);
    x2   = mul_q62(th, th);
    term = th;
    acc  = th;
    for (int n = 1; n <= 15; n++) begin
      term = udiv64(mul_q62(term, x2), 64'(2 * n) * 64'(2 * n + 1));
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    v = ((acc >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[TRIG_BITS-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QUARTER; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // ---- runtime helpers ----
  // top SINE_TABLE_BITS of the angle; zero-filled when the ROM is finer
  function automatic tidx_t angle_index(input angle_t t);
    logic [ANGLE_BITS+SINE_TABLE_BITS-1:0] w;
    w = {t, {SINE_TABLE_BITS{1'b0}}};
    return w[ANGLE_BITS+SINE_TABLE_BITS-1 -: SINE_TABLE_BITS];
  endfunction

  // full-wave sine from the quarter ROM
  function automatic trig_t sine_of(input tidx_t k);
    logic [1:0] quad;
    qidx_t      r;
    qidx_t      qi;
    trig_t      s;
    quad = k[SINE_TABLE_BITS-1 -: 2];
    r    = {1'b0, k[SINE_TABLE_BITS-3:0]};
    qi   = quad[0] ? (QUARTER_Q - r) : r;
    s    = trig_t'(QTAB[qi]);
    return quad[1] ? -s : s;
  endfunction

  // (p1 +/- p2 + 2^14) >>> 15, clamped to the coordinate range
  function automatic sat_t round_sat(input prod_t p1, input prod_t p2, input logic sub);
    sum_t s;
    shr_t r;
    sat_t o;
    s = sub ? (sum_t'(p1) - sum_t'(p2)) : (sum_t'(p1) + sum_t'(p2));
    s = s + ROUND_BIAS;
    r = shr_t'(s >>> FRAC_SHIFT);
    if (r > shr_t'(COORD_MAX)) begin
      o.v    = COORD_MAX;
      o.clip = 1'b1;
    end else if (r < shr_t'(COORD_MIN)) begin
      o.v    = COORD_MIN;
      o.clip = 1'b1;
    end else begin
      o.v    = coord_t'(r);
      o.clip = 1'b0;
    end
    return o;
  endfunction

endpackage : r3d_pkg
`default_nettype wire

// ----- design/r3d_trig.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// r3d_trig: sine/cosine lookup stage
// Maps the three angles to ROM indices and registers sin/cos with the point.
// ---------------------------------------------------------------------------
module r3d_trig
  import r3d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire pin_t  in_pt,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  logic  v_r;
  item_t item_r;
  item_t item_nxt;
  tidx_t ix;
  tidx_t iy;
  tidx_t iz;
  logic  en;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    ix = angle_index(in_pt.tx);
    iy = angle_index(in_pt.ty);
    iz = angle_index(in_pt.tz);
    item_nxt.x    = in_pt.x;
    item_nxt.y    = in_pt.y;
    item_nxt.z    = in_pt.z;
    item_nxt.sx   = sine_of(ix);
    item_nxt.cx   = sine_of(ix + QUARTER_T);
    item_nxt.sy   = sine_of(iy);
    item_nxt.cy   = sine_of(iy + QUARTER_T);
    item_nxt.sz   = sine_of(iz);
    item_nxt.cz   = sine_of(iz + QUARTER_T);
    item_nxt.clip = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;

  // the ROM never yields the full-scale negative code
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (item_r.sx != TRIG_MIN) && (item_r.cx != TRIG_MIN) &&
            (item_r.sy != TRIG_MIN) && (item_r.cy != TRIG_MIN) &&
            (item_r.sz != TRIG_MIN) && (item_r.cz != TRIG_MIN))
    else $error("trig: full-scale negative sine/cosine");

endmodule : r3d_trig
`default_nettype wire

// ----- design/r3d_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// r3d_axis: one plane rotation, two register stages
// Stage A: four 32x16 products. Stage B: round, shift, saturate.
//   u = a*c - b*s    w = a*s + b*c
// ---------------------------------------------------------------------------
module r3d_axis
  import r3d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire item_t  in_item,
  input  wire coord_t in_a,
  input  wire coord_t in_b,
  input  wire trig_t  in_s,
  input  wire trig_t  in_c,
  output logic        out_valid,
  input  wire logic   out_ready,
  output item_t       out_item,
  output coord_t      out_u,
  output coord_t      out_w
);

  // stage A
  logic  va_r;
  prod_t pac_r;
  prod_t pbs_r;
  prod_t pas_r;
  prod_t pbc_r;
  item_t item_a_r;
  // stage B
  logic   vb_r;
  coord_t u_r;
  coord_t w_r;
  logic   oclip_r;
  item_t  item_b_r;

  logic en_a;
  logic en_b;
  sat_t u_nxt;
  sat_t w_nxt;

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= in_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      pac_r    <= prod_t'(in_a) * prod_t'(in_c);
      pbs_r    <= prod_t'(in_b) * prod_t'(in_s);
      pas_r    <= prod_t'(in_a) * prod_t'(in_s);
      pbc_r    <= prod_t'(in_b) * prod_t'(in_c);
      item_a_r <= in_item;
    end
  end

  always_comb begin
    u_nxt = round_sat(pac_r, pbs_r, 1'b1);
    w_nxt = round_sat(pas_r, pbc_r, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      u_r      <= u_nxt.v;
      w_r      <= w_nxt.v;
      oclip_r  <= u_nxt.clip | w_nxt.clip;
      item_b_r <= item_a_r;
    end
  end

  always_comb begin
    out_item      = item_b_r;
    out_item.clip = item_b_r.clip | oclip_r;
  end

  assign out_valid = vb_r;
  assign out_u     = u_r;
  assign out_w     = w_r;

  // a clip here must leave one of the results pinned at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && oclip_r |-> (u_r == COORD_MAX) || (u_r == COORD_MIN) ||
                        (w_r == COORD_MAX) || (w_r == COORD_MIN))
    else $error("axis: clip flagged without a saturated result");

  // a held result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && !out_ready |=> vb_r && $stable(u_r) && $stable(w_r) && $stable(oclip_r))
    else $error("axis: stalled result changed");

endmodule : r3d_axis
`default_nettype wire

// ----- design/point_rotate_3d_euler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// point_rotate_3d_euler: Euler-angle rotation of a Q16.16 point
// Rotates about Z, then X, then Y, with Q1.15 sine/cosine from a ROM.
// ---------------------------------------------------------------------------
// Throughput is one point per clock unless the output is backpressured. There
// are seven register stages: one stage of sine/cosine lookup, then two
// stages per axis (a product stage of four 32x16 multipliers and a
// round/shift/saturate stage), three axes in series. Every stage has its own
// valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles close up and in_tready only drops when all seven stages hold items
// and the output is backpressured. The sine ROM is a quarter wave of
// QUARTER+1 entries fixed at elaboration; no clearing pass or setup is needed.
// Each axis result is (p*a + q*b + 2^14) >>> 15 clamped to 32-bit signed, and
// later axes use the clamped value. out_tuser[0] is set when any of the six
// axis results was clamped.
// ---------------------------------------------------------------------------
module point_rotate_3d_euler
  import r3d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input point
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // [31:0] in_x, [63:32] in_y, [95:64] in_z,
  // [111:96] turn_x, [127:112] turn_y, [143:128] turn_z
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,
  // rotated point
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z
  output logic [OUT_DATA_BITS-1:0]      out_tdata,
  // [0] clipped
  output logic                          out_tuser
);

  pin_t   pin;

  logic   t_valid;
  logic   t_ready;
  item_t  t_item;

  logic   zr_valid;
  logic   zr_ready;
  item_t  zr_item;
  coord_t zr_u;   // x1
  coord_t zr_w;   // y1
  item_t  zr_next;

  logic   xr_valid;
  logic   xr_ready;
  item_t  xr_item;
  coord_t xr_u;   // y2
  coord_t xr_w;   // z2
  item_t  xr_next;

  logic   yr_item_valid;
  item_t  yr_item;
  coord_t yr_u;   // z3
  coord_t yr_w;   // x3

  // unpack the slave tdata, first field lowest
  always_comb begin
    pin.x  = in_tdata[0*COORD_BITS +: COORD_BITS];
    pin.y  = in_tdata[1*COORD_BITS +: COORD_BITS];
    pin.z  = in_tdata[2*COORD_BITS +: COORD_BITS];
    pin.tx = in_tdata[3*COORD_BITS + 0*ANGLE_BITS +: ANGLE_BITS];
    pin.ty = in_tdata[3*COORD_BITS + 1*ANGLE_BITS +: ANGLE_BITS];
    pin.tz = in_tdata[3*COORD_BITS + 2*ANGLE_BITS +: ANGLE_BITS];
  end

  r3d_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pt     (pin),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .out_item  (t_item)
  );

  // about Z: x1 = x*cz - y*sz, y1 = x*sz + y*cz
  r3d_axis u_axis_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .in_item   (t_item),
    .in_a      (t_item.x),
    .in_b      (t_item.y),
    .in_s      (t_item.sz),
    .in_c      (t_item.cz),
    .out_valid (zr_valid),
    .out_ready (zr_ready),
    .out_item  (zr_item),
    .out_u     (zr_u),
    .out_w     (zr_w)
  );

  always_comb begin
    zr_next   = zr_item;
    zr_next.x = zr_u;
    zr_next.y = zr_w;
  end

  // about X: y2 = y1*cx - z*sx, z2 = y1*sx + z*cx
  r3d_axis u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (zr_valid),
    .in_ready  (zr_ready),
    .in_item   (zr_next),
    .in_a      (zr_w),
    .in_b      (zr_item.z),
    .in_s      (zr_item.sx),
    .in_c      (zr_item.cx),
    .out_valid (xr_valid),
    .out_ready (xr_ready),
    .out_item  (xr_item),
    .out_u     (xr_u),
    .out_w     (xr_w)
  );

  always_comb begin
    xr_next   = xr_item;
    xr_next.y = xr_u;
    xr_next.z = xr_w;
  end

  // about Y: z3 = z2*cy - x1*sy, x3 = z2*sy + x1*cy
  r3d_axis u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (xr_valid),
    .in_ready  (xr_ready),
    .in_item   (xr_next),
    .in_a      (xr_w),
    .in_b      (xr_item.x),
    .in_s      (xr_item.sy),
    .in_c      (xr_item.cy),
    .out_valid (yr_item_valid),
    .out_ready (out_tready),
    .out_item  (yr_item),
    .out_u     (yr_u),
    .out_w     (yr_w)
  );

  // the last axis stage register is the output register
  assign out_tvalid = yr_item_valid;
  assign out_tuser  = yr_item.clip;

  always_comb begin
    out_tdata = '0;
    out_tdata[0*COORD_BITS +: COORD_BITS] = yr_w;
    out_tdata[1*COORD_BITS +: COORD_BITS] = yr_item.y;
    out_tdata[2*COORD_BITS +: COORD_BITS] = yr_u;
  end

  // input side only backs up when the result is held by the sink
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("rotate: input stalled while output drains");

endmodule : point_rotate_3d_euler
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stream-level check of the Euler-angle point rotator
// Drives Q16.16 points with binary angles through the input stream and
// checks every rotated point, field by field, against a typed-in result or an
// in-bench predictor with its own copy of the Q1.15 sine table. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
  import r3d_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RAND_POINTS = 600;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 20;     // time for stray results after the drain
  localparam int N_DIR       = 22;

  // one rotated point as it leaves the block
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clip;
  } rotated_t;

  // directed row; known rows carry the result typed in, the rest use the predictor
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    angle_t tx;
    angle_t ty;
    angle_t tz;
    logic   known;
    coord_t ex;
    coord_t ey;
    coord_t ez;
    logic   eclip;
  } dir_row_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata   = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tuser;

  int       sine_rom [TAB_SIZE];
  rotated_t rotated_due [$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;

  // Directed points: zero point at extreme angles (result is plainly zero),
  // unit vectors at quarter turns, coordinate extremes, 45-degree turns that
  // push a stage past full scale, angles below one table step, bit patterns.
  dir_row_t dir_rows [N_DIR] = '{
    '{32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0, 32'h0, 32'h0, 16'h4000, 16'h8000, 16'hC000, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0001_0000, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0, 32'h0001_0000, 32'h0, 16'h0000, 16'h0000, 16'h4000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0, 32'h0, 32'h0001_0000, 16'h4000, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0001_0000, 32'h0, 32'h0, 16'h0000, 16'h4000, 16'h0000, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MAX, COORD_MAX, COORD_MAX, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000, 16'h0000, 16'h0000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MIN, COORD_MIN, COORD_MIN, 16'h8000, 16'h8000, 16'h8000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MAX, COORD_MAX, 32'h0, 16'h0000, 16'h0000, 16'h2000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MIN, COORD_MIN, 32'h0, 16'h0000, 16'h0000, 16'h2000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MAX, COORD_MIN, COORD_MAX, 16'h2000, 16'h2000, 16'h2000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MIN, COORD_MAX, COORD_MIN, 16'hE000, 16'h6000, 16'hA000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'h003F, 16'h0040, 16'hFFC0,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h1234_5678, 32'h8765_4321, 32'h0FED_CBA9, 16'h1234, 16'h5678, 16'h9ABC,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0, 32'h0, COORD_MAX, 16'h2000, 16'h2000, 16'h0000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{COORD_MAX, 32'h0, COORD_MAX, 16'h0000, 16'h2000, 16'h0000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h7FFF_0000, 32'h8001_0000, 32'h0, 16'hC000, 16'h4000, 16'h8000,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 16'h0001, 16'h0001, 16'h0001,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 16'h5555, 16'hAAAA,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 16'hAAAA, 16'h5555,
      1'b0, 32'h0, 32'h0, 32'h0, 1'b0}
  };

  point_rotate_3d_euler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---- sine table, Q1.15, built from a Q62 Taylor series ----
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return wide[125:62];
  endfunction

  // round(32767 * sin(pi/2 * k / QUARTER)), k in 0..QUARTER
  function automatic int quarter_wave(input int k);
    logic [63:0] th;
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    th = (HALF_PI_Q62 / 64'(QUARTER)) * 64'(k)
       + ((HALF_PI_Q62 % 64'(QUARTER)) * 64'(k)) / 64'(QUARTER);
    sq   = q62_mul(th, th);
    term = th;
    acc  = th;
    for (int n = 1; n <= 15; n++) begin
      term = q62_mul(term, sq) / (64'(2 * n) * 64'(2 * n + 1));
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    v = ((acc >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  function automatic void fill_sine_rom();
    int quad;
    int r;
    int s;
    for (int k = 0; k < TAB_SIZE; k++) begin
      quad = k / QUARTER;
      r    = k % QUARTER;
      s    = (quad % 2 == 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
      sine_rom[k] = (quad >= 2) ? -s : s;
    end
  endfunction

  // ---- predictor ----
  // (p*a + q*b + 2^14) >>> 15, floor, clamped to the coordinate range
  function automatic coord_t mix_round_sat(input longint p, input longint a,
                                           input longint q, input longint b,
                                           inout logic clip);
    longint acc;
    acc = p * a + q * b + (longint'(1) <<< (FRAC_SHIFT - 1));
    acc = acc >>> FRAC_SHIFT;
    if (acc > longint'(COORD_MAX)) begin
      clip = 1'b1;
      return COORD_MAX;
    end
    if (acc < longint'(COORD_MIN)) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    return coord_t'(acc);
  endfunction

  // rotate about Z, then X, then Y; later axes take clamped values
  function automatic rotated_t euler_rotate(input coord_t x, input coord_t y,
                                            input coord_t z, input angle_t ax,
                                            input angle_t ay, input angle_t az);
    tidx_t    ix;
    tidx_t    iy;
    tidx_t    iz;
    longint   sx, cx, sy, cy, sz, cz;
    coord_t   x1, y1, y2, z2;
    rotated_t res;
    ix = tidx_t'(ax >> (ANGLE_BITS - SINE_TABLE_BITS));
    iy = tidx_t'(ay >> (ANGLE_BITS - SINE_TABLE_BITS));
    iz = tidx_t'(az >> (ANGLE_BITS - SINE_TABLE_BITS));
    sx = sine_rom[ix];
    cx = sine_rom[tidx_t'(ix + QUARTER)];
    sy = sine_rom[iy];
    cy = sine_rom[tidx_t'(iy + QUARTER)];
    sz = sine_rom[iz];
    cz = sine_rom[tidx_t'(iz + QUARTER)];
    res.clip = 1'b0;
    x1    = mix_round_sat(x, cz, y, -sz, res.clip);
    y1    = mix_round_sat(x, sz, y, cz, res.clip);
    y2    = mix_round_sat(y1, cx, z, -sx, res.clip);
    z2    = mix_round_sat(y1, sx, z, cx, res.clip);
    res.z = mix_round_sat(z2, cy, x1, -sy, res.clip);
    res.x = mix_round_sat(z2, sy, x1, cy, res.clip);
    res.y = y2;
    return res;
  endfunction

  // ---- random sources ----
  // mostly back-to-back or short gaps, now and then a long one
  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // full range, small, medium, near full scale and the exact ends
  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return coord_t'($urandom);
    end else if (pick < 7) begin
      return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    end else if (pick == 7) begin
      case ($urandom_range(0, 3))
        0:       return COORD_MAX;
        1:       return COORD_MIN;
        2:       return coord_t'(0);
        default: return coord_t'(-1);
      endcase
    end else if (pick == 8) begin
      return $urandom_range(0, 1) ? COORD_MAX - coord_t'($urandom_range(0, 65535))
                                  : COORD_MIN + coord_t'($urandom_range(0, 65535));
    end
    return coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  // any angle, or an octant with a little jitter below and above a table step
  function automatic angle_t rand_angle();
    if ($urandom_range(0, 9) < 6) begin
      return angle_t'($urandom);
    end
    return angle_t'(($urandom_range(0, 7) << 13) +
                    ($urandom_range(0, 1) ? $urandom_range(0, 127) : 0));
  endfunction

  // ---- input side ----
  // holds the point until the transfer; returns at the accepting edge
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input angle_t ax, input angle_t ay, input angle_t az,
                            input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {az, ay, ax, z, y, x};
    do begin
      @(posedge clk);
    end while (!in_tready);
  endtask

  initial begin : drive_points
    rotated_t want;
    coord_t   px, py, pz;
    angle_t   ax, ay, az;
    logic     steady;
    fill_sine_rom();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < N_DIR; i++) begin
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                 dir_rows[i].tx, dir_rows[i].ty, dir_rows[i].tz, gap_len());
      if (dir_rows[i].known) begin
        want.x    = dir_rows[i].ex;
        want.y    = dir_rows[i].ey;
        want.z    = dir_rows[i].ez;
        want.clip = dir_rows[i].eclip;
      end else begin
        want = euler_rotate(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                            dir_rows[i].tx, dir_rows[i].ty, dir_rows[i].tz);
      end
      rotated_due.insert(rotated_due.size(), want);
    end

    // random points; every 40 points pick whether this stretch runs gap-free
    steady = 1'b0;
    for (int i = 0; i < RAND_POINTS; i++) begin
      if (i % 40 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      px = rand_coord();
      py = rand_coord();
      pz = rand_coord();
      ax = rand_angle();
      ay = rand_angle();
      az = rand_angle();
      send_point(px, py, pz, ax, ay, az, steady ? 0 : gap_len());
      rotated_due.insert(rotated_due.size(), euler_rotate(px, py, pz, ax, ay, az));
    end
    in_tvalid <= 1'b0;

    // drain, then give stray results time to show up
    while (rotated_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---- output side: ready runs of random length, short and long stalls ----
  initial begin : stall_results
    int hold;
    forever begin
      out_tready <= 1'b1;
      hold = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 12);
      repeat (hold) @(posedge clk);
      hold = gap_len();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // ---- result check: every output transfer against the oldest expectation ----
  always @(posedge clk) begin
    rotated_t want;
    coord_t   got_x, got_y, got_z;
    if (rst_n && out_tvalid && out_tready) begin
      got_x = out_tdata[COORD_BITS-1:0];
      got_y = out_tdata[2*COORD_BITS-1:COORD_BITS];
      got_z = out_tdata[3*COORD_BITS-1:2*COORD_BITS];
      if (rotated_due.size() == 0) begin
        $display("%0t: result with none expected: x %0d y %0d z %0d clip %0b",
                 $time, got_x, got_y, got_z, out_tuser);
        mismatch_count++;
      end else begin
        want = rotated_due.pop_front();
        if (got_x !== want.x) begin
          $display("%0t: out_x expected %0d, got %0d", $time, want.x, got_x);
          mismatch_count++;
        end
        if (got_y !== want.y) begin
          $display("%0t: out_y expected %0d, got %0d", $time, want.y, got_y);
          mismatch_count++;
        end
        if (got_z !== want.z) begin
          $display("%0t: out_z expected %0d, got %0d", $time, want.z, got_z);
          mismatch_count++;
        end
        if (out_tuser !== want.clip) begin
          $display("%0t: clipped expected %0b, got %0b", $time, want.clip, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, rotated_due.size());
      $display("FAIL");
      $finish;
    end
  end

endmodule

// ----- files.f -----
design/r3d_pkg.sv
design/r3d_trig.sv
design/r3d_axis.sv
design/point_rotate_3d_euler.sv
test/tb_top.sv
